/* src/stc_pkg.sv */
// Constants and types for the scrolling text console.
package stc_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RDWAIT = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  typedef struct packed {
    logic [CELL_W-1:0] entry;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } result_t;

endpackage

/* src/scrolling_text_console.sv */
// Teletype text console: screen store, cursor, scroll and cell read-back.
//
// The screen lives in one synchronous single-port RAM of ROWS x COLUMNS cells,
// used as a ring of rows: a scroll only moves the top- and bottom-row
// pointers, and a per-row fill count marks which cells of a row were written
// since it became the bottom row, so unwritten cells read as a blank (space on
// black) without any clearing pass, also right after reset. One transaction is
// handled at a time: a put goes to the hold state, a read first waits for the
// RAM data in the read-wait state and then goes to the hold state; a new
// transaction is accepted as soon as the previous result has moved into the
// output register, so it may overlap a result still waiting to be taken.
module scrolling_text_console (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stc_pkg::COLOR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [stc_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [stc_pkg::ROW_W-1:0]      read_row_i,
  input  logic [stc_pkg::COL_W-1:0]      read_column_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [stc_pkg::CELL_W-1:0]     cell_entry_o,
  output logic [stc_pkg::COL_W-1:0]      cursor_column_o,
  output logic                           scrolled_o
);
  import stc_pkg::*;

  state_e              state_q, state_d;
  logic [COLOR_W-1:0]  fg_q, bg_q;
  logic [ROW_W-1:0]    top_q, top_d, bot_q, bot_d;
  logic [COL_W-1:0]    column_q, column_d;
  logic [COL_W-1:0]    fill_q [ROWS];
  result_t             pend_q, pend_d;
  result_t             out_q;
  logic                out_valid_q, out_valid_d;
  logic                rd_oor_q, rd_blank_q;

  logic [CELL_W-1:0]   mem [CELLS];
  logic [CELL_W-1:0]   rdata_q;

  logic                accept, is_put, is_nl, do_scroll, mem_we, mem_re, load_out;
  logic [ROW_W-1:0]    wrow, top_inc;
  logic [COL_W-1:0]    wcol, newcol;
  logic [ROW_W:0]      rsum;
  logic [ROW_W-1:0]    prow;
  logic                in_range, rd_blank_d;
  logic [ADDR_W-1:0]   waddr, raddr, addr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_put     = (action_i == ACT_PUT);
  assign is_nl      = (char_code_i == NEWLINE_CODE);
  assign do_scroll  = is_nl || (column_q >= COL_W'(COLUMNS));
  assign top_inc    = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
  assign wrow       = do_scroll ? top_q : bot_q;
  assign wcol       = do_scroll ? '0 : column_q;
  assign newcol     = is_nl ? '0 : wcol + 1'b1;
  assign waddr      = ADDR_W'(wrow) * ADDR_W'(COLUMNS) + ADDR_W'(wcol);

  // logical row -> physical row in the ring
  assign rsum       = {1'b0, top_q} + {1'b0, read_row_i};
  assign prow       = (rsum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rsum - (ROW_W+1)'(ROWS))
                                                 : rsum[ROW_W-1:0];
  assign in_range   = (read_row_i < ROW_W'(ROWS)) && (read_column_i < COL_W'(COLUMNS));
  assign rd_blank_d = in_range && (read_column_i >= fill_q[prow]);
  assign raddr      = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(read_column_i);

  assign mem_we     = accept && is_put && !is_nl;
  assign mem_re     = accept && !is_put && in_range;
  assign addr       = is_put ? waddr : raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= {bg_q, fg_q, char_code_i};
    end
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  assign load_out = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    bot_d       = bot_q;
    column_d    = column_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_put) begin
            if (do_scroll) begin
              top_d = top_inc;
              bot_d = top_q;
            end
            column_d        = newcol;
            pend_d.entry    = '0;
            pend_d.col      = newcol;
            pend_d.scrolled = do_scroll;
            state_d         = ST_HOLD;
          end else begin
            pend_d.col      = column_q;
            pend_d.scrolled = 1'b0;
            state_d         = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        if (rd_oor_q) begin
          pend_d.entry = '0;
        end else if (rd_blank_q) begin
          pend_d.entry = BLANK_CELL;
        end else begin
          pend_d.entry = rdata_q;
        end
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fg_q        <= '0;
      bg_q        <= '0;
      top_q       <= '0;
      bot_q       <= ROW_W'(ROWS - 1);
      column_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      bot_q       <= bot_d;
      column_q    <= column_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FOREGROUND: fg_q <= cfg_data_i;
          REG_BACKGROUND: bg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (accept && is_put) begin
        fill_q[wrow] <= newcol;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (accept) begin
      rd_oor_q   <= !in_range;
      rd_blank_q <= rd_blank_d;
    end
    if (load_out) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_entry_o    = out_q.entry;
  assign cursor_column_o = out_q.col;
  assign scrolled_o      = out_q.scrolled;

  a_ring_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bot_q == ((top_q == '0) ? ROW_W'(ROWS - 1) : top_q - 1'b1))
    else $error("bottom row pointer out of step with top row pointer");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    column_q <= COL_W'(COLUMNS))
    else $error("cursor column beyond row width");

  a_fill_tracks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> fill_q[bot_q] == column_q)
    else $error("bottom row fill count differs from cursor column");

  a_scroll_resets_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.scrolled |-> out_q.col <= COL_W'(1))
    else $error("scrolled result with column past one");

endmodule
